// ----- hw/rtl/kway_merge_by_key_core_macros.svh -----
// assertion helpers shared by the merge core
`ifndef KWAY_MERGE_BY_KEY_CORE_MACROS_SVH
`define KWAY_MERGE_BY_KEY_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/kwm_pkg.sv -----
package kwm_pkg;

  localparam int NUM_STREAMS = 16;
  localparam int STREAM_W    = $clog2(NUM_STREAMS);
  localparam int CNT_W       = $clog2(NUM_STREAMS + 1);
  localparam int ACTIVE_W    = 5;
  localparam int DOC_W       = 32;
  localparam int APB_DATA_W  = 32;
  localparam int NUM_REGS    = 1;
  localparam int PADDR_W     = $clog2(4 * NUM_REGS) + 1;

  // word index of the configuration registers
  localparam logic REG_ACTIVE_STREAMS = 1'b0;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FINISH = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [STREAM_W-1:0] stream_index;
    logic                end_of_stream;
    logic [DOC_W-1:0]    in_doc_from;
    logic [DOC_W-1:0]    in_doc_to;
  } item_t;

  typedef struct packed {
    result_kind_t        result_kind;
    logic [DOC_W-1:0]    out_doc_from;
    logic [DOC_W-1:0]    out_doc_to;
    logic [STREAM_W-1:0] out_stream;
    logic                last_of_run;
  } result_t;

endpackage

// ----- hw/rtl/kway_merge_by_key_core.sv -----
// K-way merge of up to sixteen presorted link-record streams into one stream ordered by
// target document number, ties to the lowest stream. Each request carries one record, or an
// end mark, for one stream; it is accepted only when the core is idle. The smallest head is
// found by one shared 32-bit comparator walking the stream heads one per cycle, so every
// record or final marker takes a scan of n heads and a load of the output register, n being
// the effective active_streams count (1 to 16). A request with no result returns to idle
// after its scan; a rejected request (unknown or finished stream, or a record onto an
// occupied head) goes to the load. The output register frees the core to take the next
// request while the last result waits to be taken. active_streams sits at APB byte address
// 0; the user must write it only while the core is idle, unchecked by the core.
`include "kway_merge_by_key_core_macros.svh"

module kway_merge_by_key_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  kwm_pkg::item_t                 item,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output kwm_pkg::result_t               result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kwm_pkg::PADDR_W-1:0]    paddr,
  input  logic [kwm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kwm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import kwm_pkg::*;

  // configuration
  logic [ACTIVE_W-1:0] active_streams;
  logic [CNT_W-1:0]    eff_count;

  // stream state
  logic [DOC_W-1:0]       head_source [NUM_STREAMS];
  logic [DOC_W-1:0]       head_target [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] head_present;
  logic [NUM_STREAMS-1:0] stream_finished;
  logic                   finish_reported;

  // sequencer
  state_t state, state_next;
  logic   accept, reject, out_free, load_fire, scan_last;

  // scan accumulators
  logic [STREAM_W-1:0] scan_idx;
  logic                scan_ready, scan_found, scan_multi, best_fin;
  logic [STREAM_W-1:0] best_idx;
  logic [DOC_W-1:0]    best_src, best_tgt;

  logic                scan_ready_next, scan_found_next, scan_multi_next, best_fin_next;
  logic [STREAM_W-1:0] best_idx_next;
  logic [DOC_W-1:0]    best_src_next, best_tgt_next;
  logic                cur_pres, cur_fin, take;

  // result waiting for the output register
  result_t pend;

  // ---------------------------------------------------------------------------
  // configuration port: one register, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_streams <= ACTIVE_W'(NUM_STREAMS);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_ACTIVE_STREAMS) begin
      active_streams <= pwdata[ACTIVE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_ACTIVE_STREAMS) begin
      prdata = {{(APB_DATA_W-ACTIVE_W){1'b0}}, active_streams};
    end
  end

  // zero acts as one, anything above the stream count as the full count
  always_comb begin
    priority if (active_streams == '0) begin
      eff_count = CNT_W'(1);
    end else if (CNT_W'(active_streams) > CNT_W'(NUM_STREAMS)) begin
      eff_count = CNT_W'(NUM_STREAMS);
    end else begin
      eff_count = CNT_W'(active_streams);
    end
  end

  // ---------------------------------------------------------------------------
  // request check: stream beyond the count, finished stream, or head already full
  // ---------------------------------------------------------------------------
  assign reject = (CNT_W'(item.stream_index) >= eff_count) ||
                  stream_finished[item.stream_index] ||
                  (!item.end_of_stream && head_present[item.stream_index]);

  assign out_free  = !result_valid || !result_stall;
  assign scan_last = (CNT_W'(scan_idx) == eff_count - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // shared compare step: one head per cycle against the best so far
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_pres        = head_present[scan_idx];
    cur_fin         = stream_finished[scan_idx];
    take            = cur_pres && (!scan_found || head_target[scan_idx] < best_tgt);
    scan_ready_next = scan_ready && (cur_fin || cur_pres);
    scan_found_next = scan_found || cur_pres;
    scan_multi_next = scan_multi || (scan_found && cur_pres);
    best_idx_next   = take ? scan_idx : best_idx;
    best_src_next   = take ? head_source[scan_idx] : best_src;
    best_tgt_next   = take ? head_target[scan_idx] : best_tgt;
    best_fin_next   = take ? cur_fin : best_fin;
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = reject ? ST_LOAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          // a record is due, or the final marker once everything is drained
          if (scan_ready_next && (scan_found_next || !finish_reported)) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = pend.last_of_run ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    item_stall = 1'b1;
    load_fire  = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_SCAN: item_stall = 1'b1;
      ST_LOAD: load_fire  = out_free;
      default: item_stall = 1'b1;
    endcase
  end

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stream state updates
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head_present    <= '0;
      stream_finished <= '0;
      finish_reported <= 1'b0;
    end else begin
      if (accept && !reject) begin
        if (item.end_of_stream) begin
          stream_finished[item.stream_index] <= 1'b1;
        end else begin
          head_present[item.stream_index] <= 1'b1;
        end
      end
      // a head leaves its slot as it enters the output register
      if (load_fire && pend.result_kind == KIND_RECORD) begin
        head_present[pend.out_stream] <= 1'b0;
      end
      if (load_fire && pend.result_kind == KIND_FINISH) begin
        finish_reported <= 1'b1;
      end
    end
  end

  // head records, meaningful only while the present bit is set
  always_ff @(posedge clk) begin
    if (accept && !reject && !item.end_of_stream) begin
      head_source[item.stream_index] <= item.in_doc_from;
      head_target[item.stream_index] <= item.in_doc_to;
    end
  end

  // ---------------------------------------------------------------------------
  // scan accumulators, restarted on every pass
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      scan_idx   <= scan_idx + STREAM_W'(1);
      scan_ready <= scan_ready_next;
      scan_found <= scan_found_next;
      scan_multi <= scan_multi_next;
      best_idx   <= best_idx_next;
      best_src   <= best_src_next;
      best_tgt   <= best_tgt_next;
      best_fin   <= best_fin_next;
    end else begin
      scan_idx   <= '0;
      scan_ready <= 1'b1;
      scan_found <= 1'b0;
      scan_multi <= 1'b0;
      best_idx   <= '0;
      best_src   <= '0;
      best_tgt   <= '0;
      best_fin   <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // pending result. a record is the last of the run unless its stream is finished
  // and either another head remains or the final marker still has to follow
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && reject) begin
      pend.result_kind  <= KIND_REJECT;
      pend.out_doc_from <= '0;
      pend.out_doc_to   <= '0;
      pend.out_stream   <= item.stream_index;
      pend.last_of_run  <= 1'b1;
    end else if (state == ST_SCAN && scan_last) begin
      if (scan_found_next) begin
        pend.result_kind  <= KIND_RECORD;
        pend.out_doc_from <= best_src_next;
        pend.out_doc_to   <= best_tgt_next;
        pend.out_stream   <= best_idx_next;
        pend.last_of_run  <= !(best_fin_next && (scan_multi_next || !finish_reported));
      end else begin
        pend.result_kind  <= KIND_FINISH;
        pend.out_doc_from <= '0;
        pend.out_doc_to   <= '0;
        pend.out_stream   <= '0;
        pend.last_of_run  <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      result <= pend;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `KWM_ASSERT_NOW(a_record_from_held_head, load_fire && pend.result_kind == KIND_RECORD, head_present[pend.out_stream], "merged record taken from an empty head slot")
  `KWM_ASSERT_NOW(a_finish_once, load_fire && pend.result_kind == KIND_FINISH, !finish_reported, "final marker loaded a second time")
  `KWM_ASSERT_NEXT(a_run_continues, load_fire && !pend.last_of_run, state == ST_SCAN && item_stall, "run ended early after a result that was not last")
  `KWM_ASSERT_NOW(a_reject_alone, result_valid && result.result_kind == KIND_REJECT, result.last_of_run, "rejected request produced more than one result")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import kwm_pkg::*;

  // cycles with no request or result taken before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // quiet cycles after the last result: one full scan plus the output register, with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 30;
  localparam int NUM_PHASES = 9;
  localparam logic [PADDR_W-1:0] ACTIVE_ADDR = PADDR_W'(4 * int'(REG_ACTIVE_STREAMS));

  // running model of the merge: head slots, finished marks and the results still owed
  class merge_checker;
    bit [DOC_W-1:0] head_from [NUM_STREAMS];
    bit [DOC_W-1:0] head_to [NUM_STREAMS];
    bit head_held [NUM_STREAMS];
    bit stream_done [NUM_STREAMS];
    bit finish_sent;
    bit [ACTIVE_W-1:0] active_cfg;
    result_t pending_results [$];
    int errors;

    function new();
      active_cfg = ACTIVE_W'(16);
      finish_sent = 1'b0;
      errors = 0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head_held[i] = 1'b0;
        stream_done[i] = 1'b0;
        head_from[i] = '0;
        head_to[i] = '0;
      end
    endfunction

    // zero acts as one, anything above the stream count is clamped
    function int live_count();
      int n;
      n = int'(active_cfg);
      if (n == 0) n = 1;
      if (n > NUM_STREAMS) n = NUM_STREAMS;
      return n;
    endfunction

    // random open stream in range; with need_empty only those lacking a head
    function int pick_stream(bit need_empty);
      int picks [$];
      int n;
      n = live_count();
      for (int i = 0; i < n; i++) begin
        if (!stream_done[i] && !(need_empty && head_held[i])) picks.push_back(i);
      end
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    function void note_request(item_t it);
      int n;
      int s;
      int best;
      bit ready;
      bit found;
      bit drained;
      result_t r;
      result_t run [$];
      n = live_count();
      s = int'(it.stream_index);
      r = '0;
      // out of range, finished, or a record onto an occupied head
      if (s >= n || stream_done[s] || (!it.end_of_stream && head_held[s])) begin
        r.result_kind = KIND_REJECT;
        r.out_stream = it.stream_index;
        r.last_of_run = 1'b1;
        pending_results.push_back(r);
        return;
      end
      if (it.end_of_stream) begin
        stream_done[s] = 1'b1;
      end else begin
        head_from[s] = it.in_doc_from;
        head_to[s] = it.in_doc_to;
        head_held[s] = 1'b1;
      end
      // drain while every open stream holds a head
      while (1) begin
        ready = 1'b1;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < n; i++) begin
          if (!stream_done[i] && !head_held[i]) ready = 1'b0;
          if (head_held[i] && (!found || head_to[i] < head_to[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (!ready || !found) break;
        r = '0;
        r.result_kind = KIND_RECORD;
        r.out_doc_from = head_from[best];
        r.out_doc_to = head_to[best];
        r.out_stream = STREAM_W'(best);
        run.push_back(r);
        head_held[best] = 1'b0;
      end
      if (!finish_sent) begin
        drained = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!stream_done[i] || head_held[i]) drained = 1'b0;
        end
        if (drained) begin
          r = '0;
          r.result_kind = KIND_FINISH;
          run.push_back(r);
          finish_sent = 1'b1;
        end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[k]) pending_results.push_back(run[k]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d from %h to %h stream %0d last %0d",
                   got.result_kind, got.out_doc_from, got.out_doc_to, got.out_stream,
                   got.last_of_run);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind || got.out_doc_from !== want.out_doc_from ||
          got.out_doc_to !== want.out_doc_to || got.out_stream !== want.out_stream ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected kind %0d from %h to %h stream %0d last %0d",
                   want.result_kind, want.out_doc_from, want.out_doc_to, want.out_stream,
                   want.last_of_run);
          $display("  actual   kind %0d from %h to %h stream %0d last %0d",
                   got.result_kind, got.out_doc_from, got.out_doc_to, got.out_stream,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;

  // request channel
  logic item_valid = 1'b0;
  logic item_stall;
  item_t req_item = '0;

  // result channel
  logic result_valid;
  logic result_stall = 1'b0;
  result_t merged;

  // configuration port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // no idling on either side while set
  bit calm = 1'b0;
  int hang_count = 0;
  merge_checker sb;

  kway_merge_by_key_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(req_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(merged),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side stalls at random about 19 percent of the time
  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 19);
    end
  end

  // every taken result goes against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(merged);
  end

  // hang detection: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // mostly tiny keys so ties are common, otherwise full range or an extreme
  function automatic bit [DOC_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return DOC_W'($urandom_range(0, 15));
    if (roll < 9) return DOC_W'($urandom);
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  // present one request and hold it until taken; optionally wait out every owed result first
  task automatic push_request(item_t it, bit drain_first);
    bit gap;
    gap = !calm && ($urandom_range(0, 99) < 19);
    if (drain_first || gap) begin
      item_valid <= 1'b0;
      if (drain_first) begin
        while (sb.pending_results.size() != 0) @(posedge clk);
      end
      if (gap) repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    sb.note_request(it);
  endtask

  task automatic send_record(int s, bit [DOC_W-1:0] from_doc, bit [DOC_W-1:0] to_doc);
    item_t it;
    it = '0;
    it.stream_index = STREAM_W'(s);
    it.in_doc_from = from_doc;
    it.in_doc_to = to_doc;
    push_request(it, 1'b0);
  endtask

  // end mark with junk in the record fields, which must be ignored
  task automatic send_end(int s);
    item_t it;
    it.stream_index = STREAM_W'(s);
    it.end_of_stream = 1'b1;
    it.in_doc_from = $urandom;
    it.in_doc_to = $urandom;
    push_request(it, 1'b0);
  endtask

  // register write only once the core has gone quiet
  task automatic write_active(bit [ACTIVE_W-1:0] v);
    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ACTIVE_ADDR;
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.active_cfg = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    item_t it;
    int s;
    int roll;
    bit [ACTIVE_W-1:0] phase_counts [NUM_PHASES];
    sb = new();
    // extremes and clamped values spread over the random phases
    phase_counts = '{16, 4, 1, 31, 10, 0, 16, 2, 16};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single stream: records pass straight through, then the final marker
    write_active(1);
    send_record(0, 32'h0000_0000, 32'h0000_0000);
    send_record(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(5, 32'h0000_0001, 32'h0000_0002);   // beyond the count
    send_end(0);                                     // all finished and drained
    send_record(0, 32'h0000_0003, 32'h0000_0004);   // finished stream
    send_end(0);                                     // finished stream again

    // zero behaves like one
    write_active(0);
    send_record(1, 32'h0000_0007, 32'h0000_0007);

    // three streams with stream 0 already finished
    write_active(3);
    send_record(1, 32'hA5A5_A5A5, 32'd5);           // stream 2 still empty, nothing out
    send_record(2, 32'h5A5A_5A5A, 32'd5);           // tie goes to stream 1
    send_record(2, 32'h0000_0001, 32'd1);           // occupied head
    send_record(1, 32'h0000_0002, 32'd5);           // tie again
    send_record(1, 32'h0000_0003, 32'd9);           // stream 2 is smaller now
    send_record(2, 32'h0000_0004, 32'd20);
    send_end(2);                                     // end mark while holding a head
    send_record(15, 32'h0000_0000, 32'h0000_0000);  // beyond the count
    send_record(1, 32'h0000_0005, 32'd30);          // drains stream 2 then stream 1
    send_end(2);

    // above the stream count clamps to sixteen
    write_active(31);
    send_record(15, 32'hFFFF_FFFF, 32'h0000_0000);

    // random phases: mostly records into hungry streams, some end marks, some noise
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_active(phase_counts[ph]);
      calm <= (ph == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it = '0;
        roll = $urandom_range(0, 99);
        s = sb.pick_stream(1'b1);
        if (roll < 78 && s >= 0) begin
          it.stream_index = STREAM_W'(s);
          it.in_doc_from = $urandom;
          it.in_doc_to = pick_key();
        end else if (roll < 80) begin
          s = sb.pick_stream(1'b0);
          if (s < 0) s = $urandom_range(0, NUM_STREAMS - 1);
          it.stream_index = STREAM_W'(s);
          it.end_of_stream = 1'b1;
          it.in_doc_from = $urandom;
          it.in_doc_to = $urandom;
        end else begin
          // noise: any stream, occasionally an end mark
          it.stream_index = STREAM_W'($urandom_range(0, NUM_STREAMS - 1));
          it.end_of_stream = ($urandom_range(0, 9) == 0);
          it.in_doc_from = $urandom;
          it.in_doc_to = pick_key();
        end
        push_request(it, $urandom_range(0, 39) == 0);
      end
    end
    calm <= 1'b0;

    // let everything owed come out, then watch for strays
    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.errors += sb.pending_results.size();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
